// File: hw/rtl/mesi_pkg.sv
package mesi_pkg;

    typedef enum logic [2:0] {
        K_PR_RD    = 3'd0,
        K_PR_WR    = 3'd1,
        K_BUS_RD   = 3'd2,
        K_BUS_RDX  = 3'd3,
        K_BUS_UPGR = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_I = 2'd0,
        ST_S = 2'd1,
        ST_E = 2'd2,
        ST_M = 2'd3
    } t_coh;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_BUS_RD  = 2'd1,
        REQ_BUS_RDX = 2'd2,
        REQ_BUS_UPG = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_READ  = 2'd1,
        FSM_WRITE = 2'd2,
        FSM_CLEAR = 2'd3
    } t_fsm;

    typedef struct packed {
        logic       tag_miss;
        logic [1:0] bus_request;
        logic       write_back;
        logic       flushed;
        logic       cache_transfer;
        logic       invalidated;
        logic       intervention;
    } t_result;

endpackage

// File: hw/rtl/mesi_snooping_cache_controller_unit.sv
// MESI snooping set-associative cache controller. Each transaction (processor
// read or write, or snooped BusRd, BusRdX or BusUpgr) produces exactly one
// result transaction. The whole set (tag, allocation bit, MESI state and LRU
// rank of every way) lives in one synchronous memory row per set. The row is
// read at the edge that accepts a transaction, the update is worked out in the
// following cycle (READ state) and the updated row is written back in the WRITE
// state, which also loads the result register. The next transaction is
// accepted only after the write-back, which removes any overlap on the same
// row. After reset a clearing pass resets every row (no way allocated, rank
// equal to way index); no transaction is accepted during it. The result sits
// in an output register, so a new transaction can be accepted while the
// previous result still waits to be taken; the write-back cycle of that new
// transaction is held until the waiting result has been taken.
module mesi_snooping_cache_controller_unit #(
    parameter int NUM_SETS    = 256,
    parameter int NUM_WAYS    = 4,
    parameter int BLOCK_BYTES = 16,
    parameter int ADDR_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_addr,
    input  logic        i_others_have_copy,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tag_miss,
    output logic [1:0]  o_bus_request,
    output logic        o_write_back,
    output logic        o_flushed,
    output logic        o_cache_transfer,
    output logic        o_invalidated,
    output logic        o_intervention
);

    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_USED  = $clog2(NUM_SETS);
    localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_USED;
    localparam int RANK_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WAY_BITS  = RANK_BITS;
    localparam int CNT_BITS  = SET_BITS + 1;
    // Address as masked to ADDR_BITS, widened so that any ADDR_BITS fits.
    localparam int AW        = (ADDR_BITS > 32) ? ADDR_BITS : 32;

    typedef struct packed {
        logic                 alloc;
        logic [TAG_BITS-1:0]  tag;
        logic [1:0]           coh;
        logic [RANK_BITS-1:0] rank;
    } t_way;

    typedef t_way [NUM_WAYS-1:0] t_row;

    t_row mem [NUM_SETS];

    mesi_pkg::t_fsm r_state, n_state;
    logic [CNT_BITS-1:0] r_clr, n_clr;
    logic [2:0]          r_kind;
    logic [TAG_BITS-1:0] r_tag;
    logic [SET_BITS-1:0] r_set;
    logic                r_shared;
    t_row                r_row;
    logic                r_out_valid;
    mesi_pkg::t_result   r_res;

    logic [AW-1:0]       addr_m;
    logic [SET_BITS-1:0] in_set;
    logic [TAG_BITS-1:0] in_tag;
    logic                accept;
    logic                out_free;
    logic                mem_we;
    logic [SET_BITS-1:0] mem_waddr;
    t_row                mem_wdata;
    t_row                clr_row;
    t_row                upd_row;
    mesi_pkg::t_result   upd_res;

    always_comb begin
        addr_m = AW'(i_addr) & ((AW'(1) << ADDR_BITS) - AW'(1));
        if (ADDR_BITS >= AW) addr_m = AW'(i_addr);
    end

    assign in_tag = addr_m[ADDR_BITS-1 -: TAG_BITS];
    generate
        if (NUM_SETS > 1) begin : g_set
            assign in_set = addr_m[OFF_BITS +: SET_BITS];
        end else begin : g_noset
            assign in_set = '0;
        end
    endgenerate

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !r_out_valid || i_ready;

    // Ready whenever idle; a waiting result only holds back the write-back cycle.
    assign o_ready = (r_state == mesi_pkg::FSM_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            clr_row[w]       = '0;
            clr_row[w].rank  = RANK_BITS'(w);
        end
    end

    mesi_update #(
        .NUM_WAYS (NUM_WAYS),
        .TAG_BITS (TAG_BITS),
        .RANK_BITS(RANK_BITS),
        .WAY_BITS (WAY_BITS)
    ) u_update (
        .i_kind  (r_kind),
        .i_tag   (r_tag),
        .i_shared(r_shared),
        .i_row   (r_row),
        .o_row   (upd_row),
        .o_res   (upd_res)
    );

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            mesi_pkg::FSM_CLEAR: begin
                n_clr = r_clr + CNT_BITS'(1);
                if (r_clr == CNT_BITS'(NUM_SETS - 1)) n_state = mesi_pkg::FSM_IDLE;
            end
            mesi_pkg::FSM_IDLE:  if (accept) n_state = mesi_pkg::FSM_READ;
            mesi_pkg::FSM_READ:  n_state = mesi_pkg::FSM_WRITE;
            mesi_pkg::FSM_WRITE: if (out_free) n_state = mesi_pkg::FSM_IDLE;
            default:             n_state = mesi_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_wdata = upd_row;
        case (r_state)
            mesi_pkg::FSM_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr[SET_BITS-1:0];
                mem_wdata = clr_row;
            end
            mesi_pkg::FSM_WRITE: mem_we = out_free;
            default:             mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (accept) r_row <= mem[in_set];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mesi_pkg::FSM_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (r_state == mesi_pkg::FSM_WRITE && out_free) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_tag    <= in_tag;
            r_set    <= in_set;
            r_shared <= i_others_have_copy;
        end
        if (r_state == mesi_pkg::FSM_WRITE && out_free) r_res <= upd_res;
    end

    assign o_valid          = r_out_valid;
    assign o_tag_miss       = r_res.tag_miss;
    assign o_bus_request    = r_res.bus_request;
    assign o_write_back     = r_res.write_back;
    assign o_flushed        = r_res.flushed;
    assign o_cache_transfer = r_res.cache_transfer;
    assign o_invalidated    = r_res.invalidated;
    assign o_intervention   = r_res.intervention;

endmodule

// File: hw/rtl/mesi_update.sv
module mesi_update #(
    parameter int NUM_WAYS  = 4,
    parameter int TAG_BITS  = 24,
    parameter int RANK_BITS = 2,
    parameter int WAY_BITS  = 2
) (
    input  logic [2:0]                                         i_kind,
    input  logic [TAG_BITS-1:0]                                i_tag,
    input  logic                                               i_shared,
    input  logic [NUM_WAYS-1:0][1+TAG_BITS+2+RANK_BITS-1:0]    i_row,
    output logic [NUM_WAYS-1:0][1+TAG_BITS+2+RANK_BITS-1:0]    o_row,
    output mesi_pkg::t_result                                  o_res
);

    typedef struct packed {
        logic                 alloc;
        logic [TAG_BITS-1:0]  tag;
        logic [1:0]           coh;
        logic [RANK_BITS-1:0] rank;
    } t_way;

    t_way [NUM_WAYS-1:0]  row_in, row_out;
    logic [NUM_WAYS-1:0]  hit_vec;
    logic                 hit;
    logic [WAY_BITS-1:0]  hit_way;
    logic                 has_free;
    logic [WAY_BITS-1:0]  free_way;
    logic [WAY_BITS-1:0]  lru_way;
    logic [WAY_BITS-1:0]  sel;
    logic [RANK_BITS-1:0] sel_rank;
    logic [1:0]           st;
    logic                 is_pr;
    mesi_pkg::t_result    res;

    assign row_in = i_row;
    assign is_pr  = (i_kind == mesi_pkg::K_PR_RD) || (i_kind == mesi_pkg::K_PR_WR);

    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        lru_way  = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = row_in[w].alloc && (row_in[w].tag == i_tag);
            if (hit_vec[w]) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!row_in[w].alloc) begin
                has_free = 1'b1;
                free_way = WAY_BITS'(w);
            end
            if (row_in[w].rank == RANK_BITS'(NUM_WAYS - 1)) lru_way = WAY_BITS'(w);
        end
    end

    assign sel      = hit ? hit_way : (has_free ? free_way : lru_way);
    assign sel_rank = row_in[sel].rank;
    assign st       = row_in[sel].coh;

    always_comb begin
        row_out = row_in;
        res     = '0;
        if (is_pr) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (row_in[w].rank < sel_rank) row_out[w].rank = row_in[w].rank + RANK_BITS'(1);
            end
            row_out[sel].rank = '0;
            if (!hit) begin
                res.tag_miss       = 1'b1;
                res.write_back     = !has_free && (st == mesi_pkg::ST_M);
                row_out[sel].alloc = 1'b1;
                row_out[sel].tag   = i_tag;
                if (i_kind == mesi_pkg::K_PR_WR) begin
                    row_out[sel].coh = mesi_pkg::ST_M;
                    res.bus_request  = mesi_pkg::REQ_BUS_RDX;
                end else begin
                    row_out[sel].coh = i_shared ? mesi_pkg::ST_S : mesi_pkg::ST_E;
                    res.bus_request  = mesi_pkg::REQ_BUS_RD;
                end
            end else if (i_kind == mesi_pkg::K_PR_RD) begin
                if (st == mesi_pkg::ST_I) begin
                    row_out[sel].coh = i_shared ? mesi_pkg::ST_S : mesi_pkg::ST_E;
                    res.bus_request  = mesi_pkg::REQ_BUS_RD;
                end
            end else begin
                if (st == mesi_pkg::ST_I) res.bus_request = mesi_pkg::REQ_BUS_RDX;
                else if (st == mesi_pkg::ST_S) res.bus_request = mesi_pkg::REQ_BUS_UPG;
                row_out[sel].coh = mesi_pkg::ST_M;
            end
        end else if (hit) begin
            case (i_kind)
                mesi_pkg::K_BUS_RD: begin
                    if (st == mesi_pkg::ST_M) begin
                        row_out[sel].coh = mesi_pkg::ST_S;
                        res.intervention = 1'b1;
                        res.flushed      = 1'b1;
                        res.write_back   = 1'b1;
                    end else if (st == mesi_pkg::ST_E) begin
                        row_out[sel].coh   = mesi_pkg::ST_S;
                        res.intervention   = 1'b1;
                        res.cache_transfer = 1'b1;
                    end
                end
                mesi_pkg::K_BUS_RDX: begin
                    if (st != mesi_pkg::ST_I) begin
                        row_out[sel].coh = mesi_pkg::ST_I;
                        res.invalidated  = 1'b1;
                        res.flushed      = (st == mesi_pkg::ST_M);
                        res.write_back   = (st == mesi_pkg::ST_M);
                    end
                end
                mesi_pkg::K_BUS_UPGR: begin
                    if (st == mesi_pkg::ST_S) begin
                        row_out[sel].coh = mesi_pkg::ST_I;
                        res.invalidated  = 1'b1;
                    end
                end
                default: res = '0;
            endcase
        end
    end

    assign o_row = row_out;
    assign o_res = res;

endmodule

// File: hw/rtl/mesi_checker.sv
module mesi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_tag_miss,
    input logic [1:0] o_bus_request,
    input logic       o_write_back,
    input logic       o_flushed,
    input logic       o_cache_transfer,
    input logic       o_invalidated,
    input logic       o_intervention
);

    // A result stalled by the consumer holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bus_request) && $stable(o_write_back))
        else $error("stalled result changed");

    // A flush always writes the block back.
    a_flush_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_flushed |-> o_write_back)
        else $error("flush without write-back");

    // A miss always issues a bus request.
    a_miss_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tag_miss |-> o_bus_request != mesi_pkg::REQ_NONE
                                  && o_bus_request != mesi_pkg::REQ_BUS_UPG)
        else $error("miss without read request");

    // Only one transaction is in flight at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted twice in a row");

    // Neither a transfer nor an intervention ever comes together with an invalidation.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cache_transfer && o_invalidated) && !(o_intervention && o_invalidated))
        else $error("conflicting snoop outcomes");

endmodule

bind mesi_snooping_cache_controller_unit mesi_checker u_mesi_checker (.*);

// File: verif/tb_mesi_snooping_cache_controller_unit.sv
`timescale 1ns / 100ps

// Self-checking testbench for the MESI snooping cache controller. A behavioural
// copy of the tag store, coherence states and LRU ranks predicts one result
// for every accepted transaction. A separate process compares each result
// transaction with the oldest prediction. Stimulus is a set of named tests
// run in sequence, followed by a random phase that concentrates on a small
// pool of addresses. The small pool makes hits, evictions and snoop hits
// common.
module tb_mesi_snooping_cache_controller_unit;

    localparam int SETS  = 256;
    localparam int WAYS  = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_kind;
    logic [31:0] i_addr;
    logic        i_others_have_copy;
    logic        o_valid;
    logic        i_ready;
    logic        o_tag_miss;
    logic [1:0]  o_bus_request;
    logic        o_write_back;
    logic        o_flushed;
    logic        o_cache_transfer;
    logic        o_invalidated;
    logic        o_intervention;

    mesi_snooping_cache_controller_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_kind             (i_kind),
        .i_addr             (i_addr),
        .i_others_have_copy (i_others_have_copy),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_tag_miss         (o_tag_miss),
        .o_bus_request      (o_bus_request),
        .o_write_back       (o_write_back),
        .o_flushed          (o_flushed),
        .o_cache_transfer   (o_cache_transfer),
        .o_invalidated      (o_invalidated),
        .o_intervention     (o_intervention)
    );

    // This is the behavioural copy of the cache state.
    logic                line_alloc [SETS*WAYS];
    logic [19:0]         line_tag   [SETS*WAYS];
    mesi_pkg::t_coh      line_state [SETS*WAYS];
    logic [1:0]          line_rank  [SETS*WAYS];

    mesi_pkg::t_result pending_results[$];
    int                error_count;
    bit                recv_stall_en;

    // Addresses used by the random phase: a handful of sets, each with more
    // tags than ways, so that the LRU victim choice is exercised.
    logic [31:0] addr_pool[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic cache_reset_model();
        for (int i = 0; i < SETS * WAYS; i++) begin
            line_alloc[i] = 1'b0;
            line_tag[i]   = '0;
            line_state[i] = mesi_pkg::ST_I;
            line_rank[i]  = 2'(i % WAYS);
        end
    endtask

    // The accessed way becomes MRU. Every way that was more recent than it
    // moves down by one rank.
    function automatic void promote_way(int base, int way);
        logic [1:0] r;
        r = line_rank[base + way];
        for (int j = 0; j < WAYS; j++)
            if (line_rank[base + j] < r) line_rank[base + j]++;
        line_rank[base + way] = '0;
    endfunction

    function automatic mesi_pkg::t_result predict_access(logic [2:0] kind,
                                                         logic [31:0] addr,
                                                         logic shared);
        mesi_pkg::t_result res;
        logic [27:0]       blk;
        int                base;
        int                hit;
        int                vic;
        logic [19:0]       tg;
        mesi_pkg::t_coh    st;
        res  = '0;
        blk  = addr[31:4];
        base = int'(blk[7:0]) * WAYS;
        tg   = blk[27:8];
        hit  = WAYS;
        for (int w = WAYS - 1; w >= 0; w--)
            if (line_alloc[base + w] && line_tag[base + w] == tg) hit = w;
        if (kind == mesi_pkg::K_PR_RD || kind == mesi_pkg::K_PR_WR) begin
            if (hit == WAYS) begin
                res.tag_miss = 1'b1;
                vic = WAYS;
                for (int w = WAYS - 1; w >= 0; w--)
                    if (!line_alloc[base + w]) vic = w;
                if (vic == WAYS) begin
                    vic = 0;
                    for (int w = 0; w < WAYS; w++)
                        if (line_rank[base + w] >= line_rank[base + vic]) vic = w;
                    if (line_state[base + vic] == mesi_pkg::ST_M) res.write_back = 1'b1;
                end
                promote_way(base, vic);
                line_alloc[base + vic] = 1'b1;
                line_tag[base + vic]   = tg;
                if (kind == mesi_pkg::K_PR_WR) begin
                    line_state[base + vic] = mesi_pkg::ST_M;
                    res.bus_request = mesi_pkg::REQ_BUS_RDX;
                end else begin
                    line_state[base + vic] = shared ? mesi_pkg::ST_S : mesi_pkg::ST_E;
                    res.bus_request = mesi_pkg::REQ_BUS_RD;
                end
            end else begin
                st = line_state[base + hit];
                promote_way(base, hit);
                if (kind == mesi_pkg::K_PR_RD) begin
                    if (st == mesi_pkg::ST_I) begin
                        line_state[base + hit] = shared ? mesi_pkg::ST_S : mesi_pkg::ST_E;
                        res.bus_request = mesi_pkg::REQ_BUS_RD;
                    end
                end else begin
                    if (st == mesi_pkg::ST_I) res.bus_request = mesi_pkg::REQ_BUS_RDX;
                    else if (st == mesi_pkg::ST_S) res.bus_request = mesi_pkg::REQ_BUS_UPG;
                    line_state[base + hit] = mesi_pkg::ST_M;
                end
            end
        end else if (hit != WAYS) begin
            st = line_state[base + hit];
            case (kind)
                mesi_pkg::K_BUS_RD: begin
                    if (st == mesi_pkg::ST_M) begin
                        line_state[base + hit] = mesi_pkg::ST_S;
                        res.intervention = 1'b1;
                        res.flushed      = 1'b1;
                        res.write_back   = 1'b1;
                    end else if (st == mesi_pkg::ST_E) begin
                        line_state[base + hit] = mesi_pkg::ST_S;
                        res.intervention   = 1'b1;
                        res.cache_transfer = 1'b1;
                    end
                end
                mesi_pkg::K_BUS_RDX: begin
                    if (st != mesi_pkg::ST_I) begin
                        res.invalidated = 1'b1;
                        if (st == mesi_pkg::ST_M) begin
                            res.flushed    = 1'b1;
                            res.write_back = 1'b1;
                        end
                        line_state[base + hit] = mesi_pkg::ST_I;
                    end
                end
                mesi_pkg::K_BUS_UPGR: begin
                    if (st == mesi_pkg::ST_S) begin
                        line_state[base + hit] = mesi_pkg::ST_I;
                        res.invalidated = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    // Most gaps are short, with an occasional long one.
    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_access(logic [2:0] kind, logic [31:0] addr, logic shared,
                               bit gaps = 1'b1);
        int gap;
        gap = gaps ? random_gap() : 0;
        @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
        i_valid            <= 1'b1;
        i_kind             <= kind;
        i_addr             <= addr;
        i_others_have_copy <= shared;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_access(kind, addr, shared));
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // The result checker and the receiver's random stalls share this process.
    initial begin
        mesi_pkg::t_result exp_res;
        mesi_pkg::t_result got;
        int                stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = '{o_tag_miss, o_bus_request, o_write_back, o_flushed,
                        o_cache_transfer, o_invalidated, o_intervention};
                if (pending_results.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (got.tag_miss != exp_res.tag_miss) begin
                        $error("tag_miss expected %0d actual %0d",
                               exp_res.tag_miss, got.tag_miss);
                        error_count++;
                    end
                    if (got.bus_request != exp_res.bus_request) begin
                        $error("bus_request expected %0d actual %0d",
                               exp_res.bus_request, got.bus_request);
                        error_count++;
                    end
                    if (got.write_back != exp_res.write_back) begin
                        $error("write_back expected %0d actual %0d",
                               exp_res.write_back, got.write_back);
                        error_count++;
                    end
                    if (got.flushed != exp_res.flushed) begin
                        $error("flushed expected %0d actual %0d",
                               exp_res.flushed, got.flushed);
                        error_count++;
                    end
                    if (got.cache_transfer != exp_res.cache_transfer) begin
                        $error("cache_transfer expected %0d actual %0d",
                               exp_res.cache_transfer, got.cache_transfer);
                        error_count++;
                    end
                    if (got.invalidated != exp_res.invalidated) begin
                        $error("invalidated expected %0d actual %0d",
                               exp_res.invalidated, got.invalidated);
                        error_count++;
                    end
                    if (got.intervention != exp_res.intervention) begin
                        $error("intervention expected %0d actual %0d",
                               exp_res.intervention, got.intervention);
                        error_count++;
                    end
                end
            end
            @(negedge i_clk);
            if (!recv_stall_en) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 29) == 0) begin
                // An occasional long stall on the result side.
                stall_left = $urandom_range(10, 40);
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    // The read and write miss tests fill every way of set 1, evict the LRU
    // modified way and then hit lines in the M, S and E states.
    task automatic test_processor_accesses();
        for (int t = 0; t < 4; t++)
            send_access(mesi_pkg::K_PR_WR, {20'(t), 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_PR_RD, {20'd0, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_PR_RD, {20'd9, 8'd1, 4'h5}, 1'b1);
        send_access(mesi_pkg::K_PR_WR, {20'd9, 8'd1, 4'h5}, 1'b0);
        send_access(mesi_pkg::K_PR_RD, {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_PR_WR, {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_PR_RD, 32'hFFFF_FFFF, 1'b1);
        send_access(mesi_pkg::K_PR_WR, 32'h0000_0000, 1'b0);
    endtask

    // Snoops hit M, E and S lines, and processor accesses then hit the I lines they leave behind.
    task automatic test_snoops();
        send_access(mesi_pkg::K_BUS_RD,   {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_BUS_UPGR, {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_PR_RD,    {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_BUS_RD,   {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_BUS_RDX,  {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_PR_WR,    {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_BUS_RDX,  {20'd10, 8'd1, 4'd0}, 1'b0);
        send_access(mesi_pkg::K_BUS_RD,   32'h1234_5670, 1'b0);
        send_access(mesi_pkg::K_BUS_RDX,  32'hFFFF_FFFF, 1'b0);
    endtask

    // The unused kind codes must leave every result field at zero.
    task automatic test_unused_kinds();
        send_access(3'd5, {20'd9, 8'd1, 4'h5}, 1'b1);
        send_access(3'd6, 32'hFFFF_FFFF, 1'b0);
        send_access(3'd7, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_random(int count);
        logic [2:0]  kind;
        logic [31:0] addr;
        logic [7:0]  pool_set;
        for (int s = 0; s < 6; s++) begin
            pool_set = 8'($urandom);
            for (int t = 0; t < 7; t++)
                addr_pool.push_back({20'($urandom_range(0, 20'hFFFFF)), pool_set, 4'd0});
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) begin
                addr = addr_pool[(n / 200 % 6) * 7 + $urandom_range(0, 6)];
                addr[3:0] = 4'($urandom);
            end else begin
                addr = $urandom;
            end
            kind = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            send_access(kind, addr, 1'($urandom), n % 300 > 40);
            // Every so often the sender holds off until the block is drained.
            if (n % 250 == 249) wait_drained();
        end
    endtask

    initial begin
        error_count        = 0;
        recv_stall_en      = 1'b0;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_kind             = '0;
        i_addr             = '0;
        i_others_have_copy = 1'b0;
        cache_reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_processor_accesses();
        recv_stall_en = 1'b1;
        test_snoops();
        test_unused_kinds();
        wait_drained();
        test_random(1330);
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
